[sv/htqs_pkg.sv]
// Shared types and constants for the HTTP token or quoted-string recognizer.
// Depends on nothing; every other file of the block imports it.
package htqs_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int CONSUMED_W = 16;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CH_HTAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SP     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_OBS    = 8'h80;

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_FIRST = 5'b00010,
        MODE_TOKEN = 5'b00100,
        MODE_QSTR  = 5'b01000,
        MODE_QESC  = 5'b10000
    } mode_t;

    typedef enum logic [3:0] {
        ST_RUN      = 4'd0,
        ST_END_PRE  = 4'd1,
        ST_END      = 4'd2,
        ST_EXPECT   = 4'd3,
        ST_BAD_ESC  = 4'd4,
        ST_BAD_OCT  = 4'd5,
        ST_END_ESC  = 4'd6,
        ST_NO_CLOSE = 4'd7,
        ST_IDLE     = 4'd8
    } status_t;

    typedef struct packed {
        logic tok;
        logic qd;
        logic pair;
    } char_class_t;

    typedef struct packed {
        logic                  emit;
        logic [BYTE_W-1:0]     out_byte;
        status_t               status;
        logic [CONSUMED_W-1:0] consumed;
    } result_t;

    function automatic status_t end_status(input mode_t mode);
        status_t st;
        begin
            st = ST_END_ESC;
            unique case (mode)
                MODE_FIRST: st = ST_EXPECT;
                MODE_TOKEN: st = ST_END;
                MODE_QSTR:  st = ST_NO_CLOSE;
                default:    st = ST_END_ESC;
            endcase
            return st;
        end
    endfunction

endpackage

[sv/htqs_char_class.sv]
// Octet classifier: token character, qdtext character and quoted-pair character.
// Depends on htqs_pkg.
module htqs_char_class (
    input  logic [7:0]                data_byte,
    output htqs_pkg::char_class_t     cls
);
    import htqs_pkg::*;

    logic dec_num;
    logic is_upper;
    logic is_lower;
    logic is_tok_sym;

    assign dec_num  = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    assign is_upper = (data_byte >= 8'h41) && (data_byte <= 8'h5A);
    assign is_lower = (data_byte >= 8'h61) && (data_byte <= 8'h7A);

    always_comb begin
        unique case (data_byte)
            CH_BANG, CH_HASH, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, CH_TILDE: is_tok_sym = 1'b1;
            default: is_tok_sym = 1'b0;
        endcase
    end

    assign cls.tok  = dec_num || is_upper || is_lower || is_tok_sym;
    assign cls.qd   = (data_byte == CH_HTAB) || (data_byte == CH_SP) ||
                      (data_byte == CH_BANG) ||
                      ((data_byte >= CH_HASH) && (data_byte <= CH_LBRACK)) ||
                      ((data_byte >= CH_RBRACK) && (data_byte <= CH_TILDE)) ||
                      (data_byte >= CH_OBS);
    assign cls.pair = (data_byte == CH_HTAB) || (data_byte == CH_SP) ||
                      ((data_byte >= CH_BANG) && (data_byte <= CH_TILDE)) ||
                      (data_byte >= CH_OBS);

endmodule

[sv/htqs_step.sv]
// Per-octet parse step: next mode, next byte count and the result of one request.
// Depends on htqs_pkg and htqs_char_class.
module htqs_step #(
    parameter int COUNT_BITS = htqs_pkg::COUNT_BITS_DEFAULT
) (
    input  htqs_pkg::mode_t         mode,
    input  logic [COUNT_BITS-1:0]   count,
    input  logic                    start_req,
    input  logic                    has_byte,
    input  logic [7:0]              data_byte,
    input  logic                    last,
    output htqs_pkg::mode_t         mode_next,
    output logic [COUNT_BITS-1:0]   count_next,
    output htqs_pkg::result_t       result
);
    import htqs_pkg::*;

    localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

    char_class_t           cls;
    mode_t                 mode_eff;
    mode_t                 mode_step;
    logic [COUNT_BITS-1:0] count_eff;
    logic                  inc;
    logic                  emit;
    status_t               st;

    htqs_char_class u_class (
        .data_byte (data_byte),
        .cls       (cls)
    );

    assign mode_eff  = start_req ? MODE_FIRST : mode;
    assign count_eff = start_req ? '0 : count;

    always_comb begin
        inc       = 1'b0;
        emit      = 1'b0;
        st        = ST_RUN;
        mode_step = mode_eff;
        mode_next = mode_eff;
        if (mode_eff == MODE_IDLE) begin
            st        = ST_IDLE;
            mode_next = MODE_IDLE;
        end else if (!has_byte) begin
            st        = end_status(mode_eff);
            mode_next = MODE_IDLE;
        end else begin
            unique case (mode_eff)
                MODE_FIRST: begin
                    if (data_byte == CH_DQUOTE) begin
                        inc       = 1'b1;
                        mode_step = MODE_QSTR;
                    end else if (cls.tok) begin
                        inc       = 1'b1;
                        emit      = 1'b1;
                        mode_step = MODE_TOKEN;
                    end else begin
                        st        = ST_EXPECT;
                        mode_step = MODE_IDLE;
                    end
                end
                MODE_TOKEN: begin
                    if (cls.tok) begin
                        inc  = 1'b1;
                        emit = 1'b1;
                    end else begin
                        st        = ST_END_PRE;
                        mode_step = MODE_IDLE;
                    end
                end
                MODE_QSTR: begin
                    if (data_byte == CH_DQUOTE) begin
                        inc       = 1'b1;
                        st        = ST_END;
                        mode_step = MODE_IDLE;
                    end else if (data_byte == CH_BSLASH) begin
                        inc       = 1'b1;
                        mode_step = MODE_QESC;
                    end else if (cls.qd) begin
                        inc  = 1'b1;
                        emit = 1'b1;
                    end else begin
                        st        = ST_BAD_OCT;
                        mode_step = MODE_IDLE;
                    end
                end
                default: begin
                    if (cls.pair) begin
                        inc       = 1'b1;
                        emit      = 1'b1;
                        mode_step = MODE_QSTR;
                    end else begin
                        st        = ST_BAD_ESC;
                        mode_step = MODE_IDLE;
                    end
                end
            endcase
            mode_next = mode_step;
            if (last && (mode_step != MODE_IDLE)) begin
                st        = end_status(mode_step);
                mode_next = MODE_IDLE;
            end
        end
    end

    assign count_next = (inc && (count_eff != CountMax)) ? count_eff + 1'b1 : count_eff;

    assign result.emit     = emit;
    assign result.out_byte = emit ? data_byte : 8'h00;
    assign result.status   = st;

    generate
        if (COUNT_BITS > CONSUMED_W) begin : g_sat
            assign result.consumed = (|count_next[COUNT_BITS-1:CONSUMED_W]) ?
                                     {CONSUMED_W{1'b1}} : count_next[CONSUMED_W-1:0];
        end else if (COUNT_BITS == CONSUMED_W) begin : g_same
            assign result.consumed = count_next;
        end else begin : g_ext
            assign result.consumed = {{(CONSUMED_W-COUNT_BITS){1'b0}}, count_next};
        end
    endgenerate

endmodule

[sv/http_token_or_quoted_string_top.sv]
// Recognizes an RFC 7230 token or quoted-string one octet per request and
// returns a decoded byte, a status and the consumed count. Rate: one request
// per clock unless the result is back-pressured by m_ready; a request passes
// through the input register and then the result register, with the mode and
// count registers updated as the request moves between them.
// Depends on htqs_pkg and htqs_step.
module http_token_or_quoted_string_top #(
    parameter int COUNT_BITS = htqs_pkg::COUNT_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_req,
    input  logic        s_has_byte,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_emit,
    output logic [7:0]  m_out_byte,
    output logic [3:0]  m_status,
    output logic [15:0] m_consumed
);
    import htqs_pkg::*;

    logic                  in_valid_reg;
    logic                  in_start_reg;
    logic                  in_has_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    mode_t                 mode_reg;
    mode_t                 mode_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    result_t               res;
    logic                  m_valid_reg;
    result_t               res_reg;
    logic                  advance;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    htqs_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .mode       (mode_reg),
        .count      (count_reg),
        .start_req  (in_start_reg),
        .has_byte   (in_has_reg),
        .data_byte  (in_byte_reg),
        .last       (in_last_reg),
        .mode_next  (mode_next),
        .count_next (count_next),
        .result     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            mode_reg     <= MODE_IDLE;
            count_reg    <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                mode_reg    <= mode_next;
                count_reg   <= count_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_start_reg <= s_start_req;
            in_has_reg   <= s_has_byte;
            in_byte_reg  <= s_data_byte;
            in_last_reg  <= s_last;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_emit     = res_reg.emit;
    assign m_out_byte = res_reg.out_byte;
    assign m_status   = res_reg.status;
    assign m_consumed = res_reg.consumed;

    // A request that finishes or fails an element always leaves the parser idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (res.status != ST_RUN)) |=> (mode_reg == MODE_IDLE))
        else $error("parser not idle after a closing status");

    // Requests seen while idle and without a start leave the count untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_start_reg && (mode_reg == MODE_IDLE)) |=> $stable(count_reg))
        else $error("byte count changed while idle");

    // No accepted class contains the zero octet, so an emitted byte is never zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_emit) |-> (m_out_byte != 8'h00))
        else $error("zero octet emitted");

    // A result register only loads when it is free or being drained.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(res_reg))
        else $error("stalled result overwritten");

endmodule

[test/http_token_or_quoted_string_top_tb.sv]
// Testbench for http_token_or_quoted_string_top: drives octet requests with random gaps and
// back-pressure, predicts each decoded result in step and compares it field by field.
// Depends on htqs_pkg and the RTL of the recognizer.
`timescale 1ns / 100ps

module http_token_or_quoted_string_top_tb;
    import htqs_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int LONG_TOKEN = 48;

    typedef struct {
        logic       start;
        logic       has;
        logic [7:0] data;
        logic       last;
    } octet_req_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_start_req = 1'b0;
    logic        s_has_byte = 1'b0;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_emit;
    logic [7:0]  m_out_byte;
    logic [3:0]  m_status;
    logic [15:0] m_consumed;

    octet_req_t  pending[$];
    octet_req_t  cur_req;
    result_t     decoded_q[$];
    int          next_idx = 0;
    int          calm_start = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_left = 0;
    bit          held_once = 1'b0;
    bit          req_taken = 1'b0;
    int          results_seen = 0;
    int          err_count = 0;
    int          cycles = 0;

    mode_t                 elem_mode = MODE_IDLE;
    logic [CONSUMED_W-1:0] elem_count = '0;

    http_token_or_quoted_string_top uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_start_req(s_start_req),
        .s_has_byte(s_has_byte),
        .s_data_byte(s_data_byte),
        .s_last(s_last),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_emit(m_emit),
        .m_out_byte(m_out_byte),
        .m_status(m_status),
        .m_consumed(m_consumed)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic bit is_tchar(input logic [7:0] b);
        unique case (b)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D, 8'h2E,
            8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
            default: return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
                            (b >= 8'h61 && b <= 8'h7A);
        endcase
    endfunction

    function automatic bit is_qd_octet(input logic [7:0] b);
        return b == CH_HTAB || b == CH_SP || b == CH_BANG ||
               (b >= CH_HASH && b <= CH_LBRACK) || (b >= CH_RBRACK && b <= CH_TILDE) ||
               b >= CH_OBS;
    endfunction

    function automatic bit is_pair_octet(input logic [7:0] b);
        return b == CH_HTAB || b == CH_SP || (b >= CH_BANG && b <= CH_TILDE) || b >= CH_OBS;
    endfunction

    function automatic status_t close_status(input mode_t m);
        unique case (m)
            MODE_FIRST: return ST_EXPECT;
            MODE_TOKEN: return ST_END;
            MODE_QSTR:  return ST_NO_CLOSE;
            default:    return ST_END_ESC;
        endcase
    endfunction

    function automatic void count_octet();
        if (elem_count != {CONSUMED_W{1'b1}}) begin
            elem_count = elem_count + 1'b1;
        end
    endfunction

    function automatic result_t decode_octet(input octet_req_t r);
        result_t res;
        res.emit = 1'b0;
        res.out_byte = 8'h00;
        res.status = ST_RUN;
        if (r.start) begin
            elem_mode = MODE_FIRST;
            elem_count = '0;
        end
        if (elem_mode == MODE_IDLE) begin
            res.status = ST_IDLE;
        end else if (!r.has) begin
            res.status = close_status(elem_mode);
            elem_mode = MODE_IDLE;
        end else begin
            case (elem_mode)
                MODE_FIRST: begin
                    if (r.data == CH_DQUOTE) begin
                        count_octet();
                        elem_mode = MODE_QSTR;
                    end else if (is_tchar(r.data)) begin
                        count_octet();
                        res.emit = 1'b1;
                        res.out_byte = r.data;
                        elem_mode = MODE_TOKEN;
                    end else begin
                        res.status = ST_EXPECT;
                        elem_mode = MODE_IDLE;
                    end
                end
                MODE_TOKEN: begin
                    if (is_tchar(r.data)) begin
                        count_octet();
                        res.emit = 1'b1;
                        res.out_byte = r.data;
                    end else begin
                        res.status = ST_END_PRE;
                        elem_mode = MODE_IDLE;
                    end
                end
                MODE_QSTR: begin
                    if (r.data == CH_DQUOTE) begin
                        count_octet();
                        res.status = ST_END;
                        elem_mode = MODE_IDLE;
                    end else if (r.data == CH_BSLASH) begin
                        count_octet();
                        elem_mode = MODE_QESC;
                    end else if (is_qd_octet(r.data)) begin
                        count_octet();
                        res.emit = 1'b1;
                        res.out_byte = r.data;
                    end else begin
                        res.status = ST_BAD_OCT;
                        elem_mode = MODE_IDLE;
                    end
                end
                default: begin
                    if (is_pair_octet(r.data)) begin
                        count_octet();
                        res.emit = 1'b1;
                        res.out_byte = r.data;
                        elem_mode = MODE_QSTR;
                    end else begin
                        res.status = ST_BAD_ESC;
                        elem_mode = MODE_IDLE;
                    end
                end
            endcase
            if (r.last && elem_mode != MODE_IDLE) begin
                res.status = close_status(elem_mode);
                elem_mode = MODE_IDLE;
            end
        end
        res.consumed = elem_count;
        return res;
    endfunction

    function automatic void add_req(input logic start, input logic has, input logic [7:0] data,
                                    input logic last);
        octet_req_t r;
        r.start = start;
        r.has = has;
        r.data = data;
        r.last = last;
        pending.push_back(r);
    endfunction

    function automatic logic [7:0] pick_tchar();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (!is_tchar(b));
        return b;
    endfunction

    function automatic logic [7:0] pick_qdtext();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (!is_qd_octet(b));
        return b;
    endfunction

    function automatic logic [7:0] pick_pair_octet();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (!is_pair_octet(b));
        return b;
    endfunction

    function automatic logic [7:0] pick_non_pair();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (is_pair_octet(b));
        return b;
    endfunction

    function automatic logic [7:0] pick_delimiter();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (is_tchar(b));
        return b;
    endfunction

    function automatic logic [7:0] pick_bad_qdtext();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (is_qd_octet(b) || b == CH_DQUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic void add_token();
        int len;
        int fin;
        len = $urandom_range(1, 12);
        fin = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            add_req(i == 0, 1'b1, pick_tchar(), (i == len - 1) && fin == 0);
        end
        case (fin)
            1: add_req(1'b0, 1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            2: add_req(1'b0, 1'b1, pick_delimiter(), 1'($urandom_range(0, 1)));
            default: ;
        endcase
    endfunction

    function automatic void add_quoted();
        int len;
        int fin;
        len = $urandom_range(0, 10);
        fin = $urandom_range(0, 6);
        add_req(1'b1, 1'b1, CH_DQUOTE, 1'b0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                add_req(1'b0, 1'b1, CH_BSLASH, 1'b0);
                add_req(1'b0, 1'b1, pick_pair_octet(), 1'b0);
            end else begin
                add_req(1'b0, 1'b1, pick_qdtext(), 1'b0);
            end
        end
        case (fin)
            0, 1: add_req(1'b0, 1'b1, CH_DQUOTE, 1'($urandom_range(0, 1)));
            2: add_req(1'b0, 1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            3: add_req(1'b0, 1'b1, pick_qdtext(), 1'b1);
            4: add_req(1'b0, 1'b1, CH_BSLASH, 1'b1);
            5: begin
                if ($urandom_range(0, 1) == 0) begin
                    add_req(1'b0, 1'b1, pick_bad_qdtext(), 1'($urandom_range(0, 1)));
                end else begin
                    add_req(1'b0, 1'b1, CH_BSLASH, 1'b0);
                    add_req(1'b0, 1'b1, pick_non_pair(), 1'($urandom_range(0, 1)));
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void add_random_element();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            add_req(1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (kind < 50) begin
            add_token();
        end else if (kind < 92) begin
            add_quoted();
        end else if (kind < 96) begin
            do add_req(1'b1, 1'b1, pick_delimiter(), 1'($urandom_range(0, 1)));
            while (pending[pending.size() - 1].data == CH_DQUOTE);
        end else begin
            add_req(1'b1, 1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endfunction

    // Sender: presents the next request once the previous one is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            req_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (next_idx < calm_start && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 16);
                s_valid <= 1'b0;
            end else if (next_idx < pending.size()) begin
                cur_req = pending[next_idx];
                next_idx++;
                s_valid <= 1'b1;
                s_start_req <= cur_req.start;
                s_has_byte <= cur_req.has;
                s_data_byte <= cur_req.data;
                s_last <= cur_req.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to fill the pipeline.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!held_once && results_seen >= 200) begin
            held_once = 1'b1;
            hold_left = 299;
            m_ready <= 1'b0;
        end else if (next_idx > calm_start) begin
            m_ready <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(0, 16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t exp_res;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (decoded_q.size() == 0) begin
                    err_count++;
                    $display("%0t ns: result with no request pending, expected none, %s",
                             $time, "got");
                    $display("%0t ns:   %0h %0h %0d %0h",
                             $time, m_emit, m_out_byte, m_status, m_consumed);
                end else begin
                    exp_res = decoded_q.pop_front();
                    if (m_emit !== exp_res.emit) begin
                        err_count++;
                        $display("%0t ns: emit mismatch, expected %0h, got %0h",
                                 $time, exp_res.emit, m_emit);
                    end
                    if (m_out_byte !== exp_res.out_byte) begin
                        err_count++;
                        $display("%0t ns: out_byte mismatch, expected %02h, got %02h",
                                 $time, exp_res.out_byte, m_out_byte);
                    end
                    if (m_status !== exp_res.status) begin
                        err_count++;
                        $display("%0t ns: status mismatch, expected %0d, got %0d",
                                 $time, exp_res.status, m_status);
                    end
                    if (m_consumed !== exp_res.consumed) begin
                        err_count++;
                        $display("%0t ns: consumed mismatch, expected %0d, got %0d",
                                 $time, exp_res.consumed, m_consumed);
                    end
                end
            end
            if (s_valid && s_ready) begin
                decoded_q.push_back(decode_octet(cur_req));
                req_taken = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        add_req(1'b0, 1'b1, 8'h41, 1'b0);
        add_req(1'b1, 1'b1, 8'h21, 1'b0);
        add_req(1'b0, 1'b1, 8'h7E, 1'b0);
        add_req(1'b0, 1'b1, 8'h20, 1'b0);
        add_req(1'b1, 1'b0, 8'h00, 1'b0);
        add_req(1'b1, 1'b1, CH_DQUOTE, 1'b0);
        add_req(1'b0, 1'b1, CH_HTAB, 1'b0);
        add_req(1'b0, 1'b1, CH_OBS, 1'b0);
        add_req(1'b0, 1'b1, 8'hFF, 1'b0);
        add_req(1'b0, 1'b1, CH_BSLASH, 1'b0);
        add_req(1'b0, 1'b1, CH_DQUOTE, 1'b0);
        add_req(1'b0, 1'b1, CH_BSLASH, 1'b0);
        add_req(1'b0, 1'b1, 8'h7F, 1'b0);
        add_req(1'b1, 1'b1, CH_DQUOTE, 1'b0);
        add_req(1'b0, 1'b1, 8'h7F, 1'b0);
        add_req(1'b1, 1'b1, CH_DQUOTE, 1'b0);
        add_req(1'b0, 1'b1, CH_BSLASH, 1'b0);
        add_req(1'b0, 1'b0, 8'hFF, 1'b1);
        add_req(1'b1, 1'b1, CH_DQUOTE, 1'b1);
        add_req(1'b1, 1'b1, 8'h5A, 1'b0);
        add_req(1'b0, 1'b0, 8'h00, 1'b0);
        add_req(1'b1, 1'b1, 8'h61, 1'b0);
        add_req(1'b1, 1'b1, 8'h7A, 1'b0);
        add_req(1'b0, 1'b1, CH_DQUOTE, 1'b1);
        add_req(1'b1, 1'b1, 8'h00, 1'b1);
        add_req(1'b0, 1'b0, 8'h00, 1'b1);

        while (pending.size() < 26 + RANDOM_ITEMS) begin
            add_random_element();
        end

        // The final stretch runs without stalls: one long token closed by an end marker.
        calm_start = pending.size();
        add_req(1'b1, 1'b1, 8'h61, 1'b0);
        for (int i = 0; i < LONG_TOKEN; i++) begin
            add_req(1'b0, 1'b1, pick_tchar(), 1'b0);
        end
        add_req(1'b0, 1'b0, 8'h00, 1'b0);

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        while (next_idx < pending.size() || s_valid || decoded_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        if (err_count == 0 && decoded_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
